// ----- sv/bsp_pkg.sv -----
// Shared types, constants and parse tables of the boolean expression parser.
// Depends on nothing; every other file of the block imports it.
package bsp_pkg;

  // One request as it arrives on the input channel.
  typedef struct packed {
    logic       req_type;
    logic [2:0] token_kind;
    logic       literal_bit;
  } in_item_t;

  // One response as it leaves on the output channel.
  typedef struct packed {
    logic accepted;
    logic result_value;
    logic syntax_error;
    logic stack_overflow;
  } out_item_t;

  // Token classes; every code above the end token is a bad token.
  typedef enum logic [2:0] {
    TOK_LIT   = 3'd0,
    TOK_OR    = 3'd1,
    TOK_AND   = 3'd2,
    TOK_OPEN  = 3'd3,
    TOK_CLOSE = 3'd4,
    TOK_END   = 3'd5,
    TOK_BAD   = 3'd6
  } tok_e;

  // Classified command passed from the front to the back through the queue.
  typedef struct packed {
    logic clear;
    tok_e tok;
    logic lit_bit;
  } cmd_t;

  // Parser action kinds.
  typedef enum logic [1:0] {
    ACT_ERR    = 2'd0,
    ACT_SHIFT  = 2'd1,
    ACT_REDUCE = 2'd2,
    ACT_ACCEPT = 2'd3
  } act_kind_e;

  typedef struct packed {
    act_kind_e  kind;
    logic [3:0] arg;
  } act_t;

  // Nonterminals of the grammar.
  typedef enum logic [1:0] {
    NT_ADD   = 2'd0,
    NT_MULT  = 2'd1,
    NT_VALUE = 2'd2
  } nt_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] state;
  } goto_t;

  // One parse stack entry: parser state and the value bit it carries.
  typedef struct packed {
    logic       val;
    logic [3:0] state;
  } entry_t;

  // Rules whose value is not simply the value on top of the stack.
  localparam logic [2:0] RULE_OR    = 3'd2;
  localparam logic [2:0] RULE_AND   = 3'd4;
  localparam logic [2:0] RULE_PAREN = 3'd5;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Action table of the SLR(1) parser.
  function automatic act_t act_lookup(logic [3:0] st, tok_e tok);
    act_t a;
    a = '{kind: ACT_ERR, arg: 4'd0};
    unique case (st) inside
      4'd0, 4'd4, 4'd6, 4'd7: begin
        if (tok == TOK_LIT) a = '{kind: ACT_SHIFT, arg: 4'd5};
        if (tok == TOK_OPEN) a = '{kind: ACT_SHIFT, arg: 4'd4};
      end
      4'd1: begin
        if (tok == TOK_END) a = '{kind: ACT_ACCEPT, arg: 4'd0};
      end
      4'd2: begin
        if (tok == TOK_OR) a = '{kind: ACT_SHIFT, arg: 4'd6};
        if (tok == TOK_CLOSE || tok == TOK_END) a = '{kind: ACT_REDUCE, arg: 4'd1};
      end
      4'd3: begin
        if (tok == TOK_AND) a = '{kind: ACT_SHIFT, arg: 4'd7};
        if (tok == TOK_OR || tok == TOK_CLOSE || tok == TOK_END) begin
          a = '{kind: ACT_REDUCE, arg: 4'd3};
        end
      end
      4'd5: begin
        if (tok == TOK_OR || tok == TOK_AND || tok == TOK_CLOSE || tok == TOK_END) begin
          a = '{kind: ACT_REDUCE, arg: 4'd6};
        end
      end
      4'd8: begin
        if (tok == TOK_CLOSE) a = '{kind: ACT_SHIFT, arg: 4'd11};
      end
      4'd9: begin
        if (tok == TOK_CLOSE || tok == TOK_END) a = '{kind: ACT_REDUCE, arg: 4'd2};
      end
      4'd10: begin
        if (tok == TOK_OR || tok == TOK_CLOSE || tok == TOK_END) begin
          a = '{kind: ACT_REDUCE, arg: 4'd4};
        end
      end
      4'd11: begin
        if (tok == TOK_OR || tok == TOK_AND || tok == TOK_CLOSE || tok == TOK_END) begin
          a = '{kind: ACT_REDUCE, arg: 4'd5};
        end
      end
      default: a = '{kind: ACT_ERR, arg: 4'd0};
    endcase
    return a;
  endfunction

  // Goto table of the SLR(1) parser.
  function automatic goto_t goto_lookup(logic [3:0] st, nt_e nt);
    goto_t g;
    g = '{ok: 1'b0, state: 4'd0};
    unique case (nt)
      NT_ADD: begin
        if (st == 4'd0) g = '{ok: 1'b1, state: 4'd1};
        if (st == 4'd4) g = '{ok: 1'b1, state: 4'd8};
        if (st == 4'd6) g = '{ok: 1'b1, state: 4'd9};
      end
      NT_MULT: begin
        if (st == 4'd0 || st == 4'd4 || st == 4'd6) g = '{ok: 1'b1, state: 4'd2};
        if (st == 4'd7) g = '{ok: 1'b1, state: 4'd10};
      end
      NT_VALUE: begin
        if (st == 4'd0 || st == 4'd4 || st == 4'd6 || st == 4'd7) begin
          g = '{ok: 1'b1, state: 4'd3};
        end
      end
      default: g = '{ok: 1'b0, state: 4'd0};
    endcase
    return g;
  endfunction

  // Length of the right-hand side of each rule.
  function automatic logic [1:0] rule_len(logic [2:0] rule);
    logic [1:0] n;
    unique case (rule) inside
      3'd0:             n = 2'd2;
      3'd2, 3'd4, 3'd5: n = 2'd3;
      default:          n = 2'd1;
    endcase
    return n;
  endfunction

  // Left-hand nonterminal of each rule.
  function automatic nt_e rule_lhs(logic [2:0] rule);
    nt_e nt;
    unique case (rule) inside
      3'd0, 3'd1, 3'd2: nt = NT_ADD;
      3'd3, 3'd4:       nt = NT_MULT;
      default:          nt = NT_VALUE;
    endcase
    return nt;
  endfunction

endpackage

// ----- sv/bsp_front.sv -----
// Front end of the parser: takes input items and classifies them into commands.
// Depends on bsp_pkg; feeds bsp_queue.
module bsp_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bsp_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              push_o,
  output bsp_pkg::cmd_t     cmd_o
);
  import bsp_pkg::*;

  // An item is taken whenever the queue has room.
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the token; codes beyond the end token become a bad token.
  always_comb begin
    cmd_o.clear   = in_item_i.req_type;
    cmd_o.lit_bit = in_item_i.literal_bit;
    if (in_item_i.token_kind > 3'(TOK_END)) begin
      cmd_o.tok = TOK_BAD;
    end else begin
      cmd_o.tok = tok_e'(in_item_i.token_kind);
    end
  end

endmodule

// ----- sv/bsp_queue.sv -----
// Short command queue that decouples the front end from the parse engine.
// Depends on bsp_pkg for the command type and the queue depth.
module bsp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bsp_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output bsp_pkg::cmd_t pop_data_o,
  output logic          empty_o
);
  import bsp_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o     = count_q == CW'(QUEUE_DEPTH);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ----- sv/bsp_back.sv -----
// Parse engine: runs shifts and chains of reductions on the parse stack memory
// and registers one response per command. Depends on bsp_pkg.
module bsp_back #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  bsp_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsp_pkg::out_item_t out_item_o
);
  import bsp_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int SW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACT,
    S_RED,
    S_RESP
  } state_e;

  state_e        state_q;
  cmd_t          cmd_q;
  entry_t        tos_q;
  logic [SW-1:0] sp_q;
  logic          err_q, ovf_q, last_q, acc_q;
  logic [2:0]    rule_q;
  logic          out_valid_q;
  out_item_t     out_item_q;

  // Stack memory below the top entry, with registered reads.
  entry_t        stack_mem [STACK_DEPTH];
  entry_t        rd_val_q, rd_below_q;

  act_t          act;
  logic [1:0]    act_len, red_len;
  logic          red_ok, stack_full, out_free, resp_fire;
  logic          mem_we, rd_en;
  logic [AW-1:0] addr_val, addr_below;
  logic          red_val;
  goto_t         red_goto;
  logic          shift_val;

  // Decode the current action and the stack addresses a reduction needs.
  always_comb begin
    act        = act_lookup(tos_q.state, cmd_q.tok);
    act_len    = rule_len(act.arg[2:0]);
    red_ok     = sp_q > SW'(act_len);
    stack_full = sp_q == SW'(STACK_DEPTH);
    if (act.arg[2:0] == RULE_PAREN) begin
      addr_val = AW'(sp_q - SW'(2));
    end else begin
      addr_val = AW'(sp_q - SW'(3));
    end
    addr_below = AW'(sp_q - SW'(act_len) - SW'(1));
    mem_we     = (state_q == S_ACT) && (act.kind == ACT_SHIFT) && !stack_full;
    rd_en      = (state_q == S_ACT) && (act.kind == ACT_REDUCE) && red_ok;
    shift_val  = (cmd_q.tok == TOK_LIT) ? cmd_q.lit_bit : 1'b0;
  end

  // Finish a reduction once the read data is back.
  always_comb begin
    red_len  = rule_len(rule_q);
    red_goto = goto_lookup(rd_below_q.state, rule_lhs(rule_q));
    case (rule_q)
      RULE_OR:    red_val = tos_q.val | rd_val_q.val;
      RULE_AND:   red_val = tos_q.val & rd_val_q.val;
      RULE_PAREN: red_val = rd_val_q.val;
      default:    red_val = tos_q.val;
    endcase
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign resp_fire   = (state_q == S_RESP) && out_free;
  assign cmd_pop_o   = (state_q == S_IDLE) && cmd_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The old top entry moves into memory on a shift; reductions read two entries.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[AW'(sp_q - SW'(1))] <= tos_q;
    end
    if (rd_en) begin
      rd_val_q   <= stack_mem[addr_val];
      rd_below_q <= stack_mem[addr_below];
    end
  end

  // Sequencer, parser registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '{clear: 1'b0, tok: TOK_BAD, lit_bit: 1'b0};
      tos_q       <= '0;
      sp_q        <= SW'(1);
      err_q       <= 1'b0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      acc_q       <= 1'b0;
      rule_q      <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      // Load a new response, or drop the one the receiver has just taken.
      if (resp_fire) begin
        out_valid_q <= 1'b1;
        out_item_q  <= '{accepted: acc_q, result_value: last_q,
                         syntax_error: err_q, stack_overflow: ovf_q};
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            acc_q <= 1'b0;
            if (cmd_i.clear) begin
              tos_q   <= '0;
              sp_q    <= SW'(1);
              err_q   <= 1'b0;
              ovf_q   <= 1'b0;
              last_q  <= 1'b0;
              state_q <= S_RESP;
            end else if (err_q || ovf_q) begin
              state_q <= S_RESP;
            end else begin
              state_q <= S_ACT;
            end
          end
        end
        S_ACT: begin
          unique case (act.kind)
            ACT_ACCEPT: begin
              last_q  <= tos_q.val;
              acc_q   <= 1'b1;
              state_q <= S_RESP;
            end
            ACT_SHIFT: begin
              if (stack_full) begin
                ovf_q <= 1'b1;
              end else begin
                tos_q <= '{val: shift_val, state: act.arg};
                sp_q  <= sp_q + SW'(1);
              end
              state_q <= S_RESP;
            end
            ACT_REDUCE: begin
              if (red_ok) begin
                rule_q  <= act.arg[2:0];
                state_q <= S_RED;
              end else begin
                err_q   <= 1'b1;
                state_q <= S_RESP;
              end
            end
            default: begin
              err_q   <= 1'b1;
              state_q <= S_RESP;
            end
          endcase
        end
        S_RED: begin
          if (red_goto.ok) begin
            tos_q   <= '{val: red_val, state: red_goto.state};
            sp_q    <= sp_q - SW'(red_len) + SW'(1);
            state_q <= S_ACT;
          end else begin
            err_q   <= 1'b1;
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/boolean_expression_slr_parser.sv -----
// Boolean expression SLR(1) parser: one token item in, one response item out.
// Instantiates bsp_front, bsp_queue and bsp_back; depends on bsp_pkg.
//
// Each item passes through the parse engine from idle to action decode and then
// to the response state; every reduction the token sets off adds a pass through
// the reduce state and back to action decode, as the parse stack memory is read
// through a register before a reduction can finish. A clear request or a token
// on a stopped parser goes from idle straight to the response state, which waits
// while the output register holds a response not yet taken. A two-entry command
// queue lets the input side keep accepting items while it has room, also while
// the engine works or a response waits.
// The parse stack needs no clearing after reset.
module boolean_expression_slr_parser #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bsp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsp_pkg::out_item_t out_item_o
);
  import bsp_pkg::*;

  logic q_full, q_empty, q_push, q_pop;
  cmd_t push_cmd, pop_cmd;

  // Input handshake and token classification.
  bsp_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .cmd_o      (push_cmd)
  );

  // Command queue between the two halves.
  bsp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (pop_cmd),
    .empty_o     (q_empty)
  );

  // Parse engine with its stack and the output register.
  bsp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_empty),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
